>>> src/lps_pkg.sv
// Shared constants and codes for the line pixel stepper.
package lps_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int REG_W          = 12;
    localparam int ADDR_W         = 22;
    localparam int COLOUR_W       = 32;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;

    // Register select taken from paddr[2] (word addressing).
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Command codes carried in the input tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

>>> src/line_pixel_stepper_top.sv
// Line rasterizer: decode, error-term stepper and address stages.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  s_axis   | in        | tvalid / tready      | tuser: command; tdata: endpoints, colour
//  m_axis   | out       | tvalid / tready      | tuser: on_screen; tdata: x, y, addr, colour
//  apb      | in        | psel, penable, pready| screen_width at 0x0, screen_height at 0x4
//
// One word is accepted per cycle while s_axis tready is high; a word that yields a pixel
// moves through the stepper register and then the address multiply into the output register.
// The stepper stage carries the line state, so consecutive step words are processed
// in back-to-back cycles. Reset clears the pipeline valids, the busy flag and loads
// the screen size defaults; no clearing pass is needed. A stall on m_axis holds each
// stage in place, and tready on s_axis drops only when every stage holds a word.
module line_pixel_stepper_top
#(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W =
        ((4 * COORD_BITS + lps_pkg::COLOUR_W + 7) / 8) * 8,
    localparam int OUT_DATA_W =
        ((2 * COORD_BITS + lps_pkg::ADDR_W + lps_pkg::COLOUR_W + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // From bit 0: start_x, start_y, end_x, end_y, line_colour.
    input  logic [IN_DATA_W-1:0]            s_axis_tdata,
    // Bit 0: command.
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0: pixel_x, pixel_y, pixel_address, pixel_colour, zero fill.
    output logic [OUT_DATA_W-1:0]           m_axis_tdata,
    // Bit 0: on_screen.
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import lps_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int LEN_W  = COORD_BITS + 1;
    localparam int ERR_W  = COORD_BITS + 2;
    localparam int PROD_W = COORD_BITS + REG_W;

    // ---------------- configuration ----------------
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_SCREEN_HEIGHT) ? APB_DATA_W'(height_reg)
                                                       : APB_DATA_W'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCREEN_WIDTH:  width_reg  <= pwdata[REG_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= pwdata[REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic dec_valid_reg;
    logic pix_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic pix_adv;
    logic dec_adv;
    logic in_fire;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign pix_adv       = !pix_valid_reg || out_adv;
    assign dec_adv       = !dec_valid_reg || pix_adv;
    assign s_axis_tready = dec_adv;
    assign in_fire       = s_axis_tvalid && dec_adv;

    // ---------------- decode stage ----------------
    logic signed [CB-1:0]    in_sx;
    logic signed [CB-1:0]    in_sy;
    logic signed [CB-1:0]    in_ex;
    logic signed [CB-1:0]    in_ey;
    logic [COLOUR_W-1:0]     in_colour;
    logic signed [LEN_W-1:0] in_dx;
    logic signed [LEN_W-1:0] in_dy;
    logic [LEN_W-1:0]        in_abs_dx;
    logic [LEN_W-1:0]        in_abs_dy;
    logic                    in_ymaj;

    assign in_sx     = s_axis_tdata[CB-1:0];
    assign in_sy     = s_axis_tdata[2*CB-1:CB];
    assign in_ex     = s_axis_tdata[3*CB-1:2*CB];
    assign in_ey     = s_axis_tdata[4*CB-1:3*CB];
    assign in_colour = s_axis_tdata[4*CB+COLOUR_W-1:4*CB];
    assign in_dx     = LEN_W'(in_ex) - LEN_W'(in_sx);
    assign in_dy     = LEN_W'(in_ey) - LEN_W'(in_sy);
    assign in_abs_dx = in_dx[LEN_W-1] ? LEN_W'(-in_dx) : LEN_W'(in_dx);
    assign in_abs_dy = in_dy[LEN_W-1] ? LEN_W'(-in_dy) : LEN_W'(in_dy);
    assign in_ymaj   = in_abs_dy > in_abs_dx;

    logic                dec_cmd_reg;
    logic [CB-1:0]       dec_x_reg;
    logic [CB-1:0]       dec_y_reg;
    logic [LEN_W-1:0]    dec_major_reg;
    logic [LEN_W-1:0]    dec_minor_reg;
    logic                dec_xneg_reg;
    logic                dec_yneg_reg;
    logic                dec_ymaj_reg;
    logic [COLOUR_W-1:0] dec_colour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (dec_adv)
        begin
            dec_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dec_cmd_reg    <= s_axis_tuser;
            dec_x_reg      <= in_sx;
            dec_y_reg      <= in_sy;
            dec_major_reg  <= in_ymaj ? in_abs_dy : in_abs_dx;
            dec_minor_reg  <= in_ymaj ? in_abs_dx : in_abs_dy;
            dec_xneg_reg   <= in_dx[LEN_W-1];
            dec_yneg_reg   <= in_dy[LEN_W-1];
            dec_ymaj_reg   <= in_ymaj;
            dec_colour_reg <= in_colour;
        end
    end

    // ---------------- stepper stage ----------------
    logic [CB-1:0]       cur_x_reg;
    logic [CB-1:0]       cur_y_reg;
    logic [LEN_W-1:0]    major_reg;
    logic [LEN_W-1:0]    minor_reg;
    logic [ERR_W-1:0]    err_reg;
    logic [LEN_W-1:0]    steps_reg;
    logic                xneg_reg;
    logic                yneg_reg;
    logic                ymaj_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic                busy_reg;

    logic                is_start;
    logic                work;
    logic                emit;
    logic [CB-1:0]       b_x;
    logic [CB-1:0]       b_y;
    logic [LEN_W-1:0]    b_major;
    logic [LEN_W-1:0]    b_minor;
    logic [ERR_W-1:0]    b_err;
    logic [LEN_W-1:0]    b_steps;
    logic                b_xneg;
    logic                b_yneg;
    logic                b_ymaj;
    logic [COLOUR_W-1:0] b_colour;
    logic [CB-1:0]       step_x;
    logic [CB-1:0]       step_y;
    logic [ERR_W-1:0]    err_sum;
    logic                err_wrap;
    logic [ERR_W-1:0]    err_next;
    logic [CB-1:0]       x_next;
    logic [CB-1:0]       y_next;
    logic [LEN_W-1:0]    steps_next;

    assign is_start = (dec_cmd_reg == CMD_START);
    assign work     = dec_valid_reg && pix_adv;

    // A start word walks from its own endpoints; a step word walks from the held state.
    always_comb
    begin
        if (is_start)
        begin
            b_x      = dec_x_reg;
            b_y      = dec_y_reg;
            b_major  = dec_major_reg;
            b_minor  = dec_minor_reg;
            b_err    = '0;
            b_steps  = dec_major_reg;
            b_xneg   = dec_xneg_reg;
            b_yneg   = dec_yneg_reg;
            b_ymaj   = dec_ymaj_reg;
            b_colour = dec_colour_reg;
            emit     = (dec_major_reg != '0);
        end
        else
        begin
            b_x      = cur_x_reg;
            b_y      = cur_y_reg;
            b_major  = major_reg;
            b_minor  = minor_reg;
            b_err    = err_reg;
            b_steps  = steps_reg;
            b_xneg   = xneg_reg;
            b_yneg   = yneg_reg;
            b_ymaj   = ymaj_reg;
            b_colour = colour_reg;
            emit     = busy_reg;
        end
    end

    assign step_x     = b_xneg ? '1 : CB'(1);
    assign step_y     = b_yneg ? '1 : CB'(1);
    assign err_sum    = b_err + ERR_W'(b_minor);
    assign err_wrap   = err_sum >= ERR_W'(b_major);
    assign err_next   = err_wrap ? err_sum - ERR_W'(b_major) : err_sum;
    // The major axis moves on every pixel, the minor one only when the error wraps.
    assign x_next     = (!b_ymaj || err_wrap) ? b_x + step_x : b_x;
    assign y_next     = (b_ymaj || err_wrap) ? b_y + step_y : b_y;
    assign steps_next = b_steps - LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (work && (is_start || busy_reg))
            begin
                busy_reg <= emit && (steps_next != '0);
            end
            if (pix_adv)
            begin
                pix_valid_reg <= dec_valid_reg && emit;
            end
        end
    end

    logic [CB-1:0]       pix_x_reg;
    logic [CB-1:0]       pix_y_reg;
    logic [COLOUR_W-1:0] pix_colour_reg;
    logic                pix_last_reg;

    always_ff @(posedge clk)
    begin
        if (work && emit)
        begin
            cur_x_reg      <= x_next;
            cur_y_reg      <= y_next;
            major_reg      <= b_major;
            minor_reg      <= b_minor;
            err_reg        <= err_next;
            steps_reg      <= steps_next;
            xneg_reg       <= b_xneg;
            yneg_reg       <= b_yneg;
            ymaj_reg       <= b_ymaj;
            colour_reg     <= b_colour;
            pix_x_reg      <= b_x;
            pix_y_reg      <= b_y;
            pix_colour_reg <= b_colour;
            pix_last_reg   <= (b_steps == LEN_W'(1));
        end
    end

    // ---------------- address stage ----------------
    logic              pix_on;
    logic [PROD_W-1:0] pix_prod;
    logic [PROD_W:0]   pix_sum;
    logic [ADDR_W-1:0] pix_addr;

    assign pix_on   = !pix_x_reg[CB-1] && !pix_y_reg[CB-1]
                      && (PROD_W'(pix_x_reg) < PROD_W'(width_reg))
                      && (PROD_W'(pix_y_reg) < PROD_W'(height_reg));
    assign pix_prod = PROD_W'(pix_y_reg) * PROD_W'(width_reg);
    assign pix_sum  = (PROD_W + 1)'(pix_prod) + (PROD_W + 1)'(pix_x_reg);
    assign pix_addr = pix_on ? ADDR_W'(pix_sum) : '0;

    logic [CB-1:0]       out_x_reg;
    logic [CB-1:0]       out_y_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic                out_on_reg;
    logic                out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && pix_valid_reg)
        begin
            out_x_reg      <= pix_x_reg;
            out_y_reg      <= pix_y_reg;
            out_addr_reg   <= pix_addr;
            out_colour_reg <= pix_colour_reg;
            out_on_reg     <= pix_on;
            out_last_reg   <= pix_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_colour_reg, out_addr_reg, out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_on_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
